// File: rtl/ktls_pkg.sv
`default_nettype none
package ktls_pkg;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;
  localparam int   NUM_COMP  = 3;

  typedef struct packed {
    logic               opcode;
    logic        [5:0]  key_slot;
    logic        [31:0] key_time;
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic signed [31:0] key_z;
    logic        [31:0] query_time;
  } in_item_t;

  typedef struct packed {
    logic               valid_res;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic        [6:0]  next_key;
  } out_item_t;

  typedef struct packed {
    logic [31:0] t;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } key_t;

  typedef enum logic [1:0] {
    ADDR_MID,
    ADDR_LO_M1,
    ADDR_LO,
    ADDR_ZERO
  } addr_sel_e;

  typedef struct packed {
    logic      wr_key;
    logic      start;
    logic      mem_rd;
    addr_sel_e addr_sel;
    logic      search_upd;
    logic      load_a;
    logic      copy_a;
    logic      div_init;
    logic      div_step;
    logic      mul;
    logic      add;
    logic [1:0] comp;
    logic      out_load;
    logic      out_empty;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic search_done;
    logic lo_zero;
    logic lo_at_n;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/ktls_if.sv
`default_nettype none
interface ktls_in_if;
  import ktls_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ktls_out_if;
  import ktls_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/ktls_ram.sv
`default_nettype none
module ktls_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

// File: rtl/ktls_ctrl.sv
`default_nettype none
module ktls_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           in_opcode_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output ktls_pkg::cmd_t      cmd_o,
  input  wire ktls_pkg::sts_t sts_i
);
  import ktls_pkg::*;

  localparam int CW = $clog2(FRAC_BITS);

  typedef enum logic [3:0] {
    S_IDLE, S_SRD, S_SCMP, S_ARD, S_AWT, S_BRD, S_BWT, S_DIV, S_MUL, S_ADD, S_FIN
  } state_e;

  state_e      state_q;
  logic [CW-1:0] cnt_q;
  logic [1:0]  comp_q;
  logic        empty_q;
  logic        res_valid_q;
  logic        accept;
  logic        out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = res_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !res_valid_q || out_ready_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.addr_sel = ADDR_MID;
    cmd_o.comp     = comp_q;
    cmd_o.out_empty = empty_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.wr_key = accept && (in_opcode_i == OP_LOAD);
        cmd_o.start  = accept && (in_opcode_i == OP_SAMPLE);
      end
      S_SRD: begin
        cmd_o.mem_rd = !sts_i.search_done;
      end
      S_SCMP: cmd_o.search_upd = 1'b1;
      S_ARD: begin
        cmd_o.mem_rd   = 1'b1;
        cmd_o.addr_sel = sts_i.lo_zero ? ADDR_ZERO : ADDR_LO_M1;
      end
      S_AWT: begin
        cmd_o.load_a = 1'b1;
        cmd_o.copy_a = sts_i.lo_zero || sts_i.lo_at_n;
      end
      S_BRD: begin
        cmd_o.mem_rd   = 1'b1;
        cmd_o.addr_sel = ADDR_LO;
      end
      S_BWT:  cmd_o.div_init = 1'b1;
      S_DIV:  cmd_o.div_step = 1'b1;
      S_MUL:  cmd_o.mul      = 1'b1;
      S_ADD:  cmd_o.add      = 1'b1;
      S_FIN:  cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      comp_q      <= '0;
      empty_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_FIN) && out_free) begin
        res_valid_q <= 1'b1;
      end else if (res_valid_q && out_ready_i) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept && (in_opcode_i == OP_SAMPLE)) begin
            empty_q <= sts_i.n_zero;
            state_q <= sts_i.n_zero ? S_FIN : S_SRD;
          end
        end
        S_SRD:  state_q <= sts_i.search_done ? S_ARD : S_SCMP;
        S_SCMP: state_q <= S_SRD;
        S_ARD:  state_q <= S_AWT;
        S_AWT:  state_q <= (sts_i.lo_zero || sts_i.lo_at_n) ? S_FIN : S_BRD;
        S_BRD:  state_q <= S_BWT;
        S_BWT: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(FRAC_BITS - 1)) begin
            comp_q  <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: state_q <= S_ADD;
        S_ADD: begin
          comp_q  <= comp_q + 2'd1;
          state_q <= (comp_q == 2'(NUM_COMP - 1)) ? S_FIN : S_MUL;
        end
        S_FIN: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> state_q != S_IDLE)
    else $error("sample transfer did not start work");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!res_valid_q || out_ready_i))
    else $error("result register overwritten");
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> cnt_q <= CW'(FRAC_BITS - 1))
    else $error("divider count out of range");
  a_comp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL || state_q == S_ADD) |-> comp_q < 2'(NUM_COMP))
    else $error("component index out of range");
endmodule
`default_nettype wire

// File: rtl/ktls_dp.sv
`default_nettype none
module ktls_dp #(
  parameter int MAX_KEYS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [6:0]           cfg_data_i,
  input  wire ktls_pkg::in_item_t   in_data_i,
  input  wire ktls_pkg::cmd_t       cmd_i,
  output ktls_pkg::sts_t            sts_o,
  output ktls_pkg::out_item_t       out_data_o
);
  import ktls_pkg::*;

  localparam int IDX_W  = $clog2(MAX_KEYS);
  localparam int CNT_W  = $clog2(MAX_KEYS + 1);
  localparam int PROD_W = 34 + FRAC_BITS;

  logic [6:0]        key_count_q;
  logic [CNT_W-1:0]  n_w, n_q, lo_q, hi_q, mid_w;
  logic [CNT_W:0]    mid_sum_w;
  logic [31:0]       q_q, t0_q, rem_q, den_q;
  logic [32:0]       rem_sh_w;
  logic [FRAC_BITS-1:0] quo_q;
  logic [31:0]       a_q [NUM_COMP];
  logic [31:0]       b_q [NUM_COMP];
  logic [31:0]       res_q [NUM_COMP];
  logic signed [32:0] diff_w;
  logic signed [PROD_W-1:0] prod_q, prod_sh_w;
  logic [IDX_W-1:0]  raddr_w;
  logic              we_w;
  key_t              wkey_w, rkey_w;
  logic [$bits(key_t)-1:0] rdata_w;
  out_item_t         out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
    end else if (cfg_we_i) begin
      key_count_q <= cfg_data_i;
    end
  end

  assign n_w       = (32'(key_count_q) > 32'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : CNT_W'(key_count_q);
  assign mid_sum_w = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_w     = CNT_W'(mid_sum_w >> 1);

  always_comb begin
    case (cmd_i.addr_sel)
      ADDR_MID:   raddr_w = IDX_W'(mid_w);
      ADDR_LO_M1: raddr_w = IDX_W'(lo_q - CNT_W'(1));
      ADDR_LO:    raddr_w = IDX_W'(lo_q);
      ADDR_ZERO:  raddr_w = '0;
      default:    raddr_w = '0;
    endcase
  end

  assign we_w   = cmd_i.wr_key && (32'(in_data_i.key_slot) < 32'(MAX_KEYS));
  assign wkey_w = '{t: in_data_i.key_time, x: in_data_i.key_x,
                    y: in_data_i.key_y, z: in_data_i.key_z};
  assign rkey_w = key_t'(rdata_w);

  ktls_ram #(.WIDTH($bits(key_t)), .DEPTH(MAX_KEYS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we_w),
    .waddr_i (IDX_W'(in_data_i.key_slot)),
    .wdata_i (wkey_w),
    .re_i    (cmd_i.mem_rd),
    .raddr_i (raddr_w),
    .rdata_o (rdata_w)
  );

  assign sts_o.n_zero      = (n_w == '0);
  assign sts_o.search_done = (lo_q >= hi_q);
  assign sts_o.lo_zero     = (lo_q == '0);
  assign sts_o.lo_at_n     = (lo_q == n_q);

  assign rem_sh_w  = {rem_q, 1'b0};
  assign diff_w    = {b_q[cmd_i.comp][31], b_q[cmd_i.comp]}
                   - {a_q[cmd_i.comp][31], a_q[cmd_i.comp]};
  assign prod_sh_w = prod_q >>> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      q_q  <= in_data_i.query_time;
      n_q  <= n_w;
      lo_q <= '0;
      hi_q <= n_w;
    end
    if (cmd_i.search_upd) begin
      if (rkey_w.t <= q_q) begin
        lo_q <= mid_w + CNT_W'(1);
      end else begin
        hi_q <= mid_w;
      end
    end
    if (cmd_i.load_a) begin
      t0_q   <= rkey_w.t;
      a_q[0] <= rkey_w.x;
      a_q[1] <= rkey_w.y;
      a_q[2] <= rkey_w.z;
    end
    if (cmd_i.copy_a) begin
      res_q[0] <= rkey_w.x;
      res_q[1] <= rkey_w.y;
      res_q[2] <= rkey_w.z;
    end
    if (cmd_i.div_init) begin
      b_q[0] <= rkey_w.x;
      b_q[1] <= rkey_w.y;
      b_q[2] <= rkey_w.z;
      rem_q  <= q_q - t0_q;
      den_q  <= rkey_w.t - t0_q;
      quo_q  <= '0;
    end
    if (cmd_i.div_step) begin
      if (rem_sh_w >= {1'b0, den_q}) begin
        rem_q <= 32'(rem_sh_w - {1'b0, den_q});
        quo_q <= {quo_q[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh_w[31:0];
        quo_q <= {quo_q[FRAC_BITS-2:0], 1'b0};
      end
    end
    if (cmd_i.mul) begin
      prod_q <= diff_w * $signed({1'b0, quo_q});
    end
    if (cmd_i.add) begin
      res_q[cmd_i.comp] <= a_q[cmd_i.comp] + prod_sh_w[31:0];
    end
    if (cmd_i.out_load) begin
      if (cmd_i.out_empty) begin
        out_q <= '0;
      end else begin
        out_q.valid_res <= 1'b1;
        out_q.out_x     <= res_q[0];
        out_q.out_y     <= res_q[1];
        out_q.out_z     <= res_q[2];
        out_q.next_key  <= 7'(lo_q);
      end
    end
  end

  assign out_data_o = out_q;
endmodule
`default_nettype wire

// File: rtl/keyframe_track_lerp_sampler_unit.sv
// A load is written to the key RAM as it is accepted. A sample's run time is set by the
// search reads of the single key RAM port, the one-bit-per-cycle fraction divider
// and one shared multiplier over 3 components.
// Throughput: one sample at a time; a new transfer is taken while a result waits.
// Reset clears key_count to 0 and all control; key storage is not cleared.
`default_nettype none
module keyframe_track_lerp_sampler_unit #(
  parameter int MAX_KEYS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [6:0] cfg_data_i,
  ktls_in_if.sink         in_i,
  ktls_out_if.source      out_o
);
  import ktls_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ktls_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.data.opcode),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ktls_dp #(.MAX_KEYS(MAX_KEYS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_i.data),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_o.data)
  );
endmodule
`default_nettype wire

// File: tb/keyframe_track_lerp_sampler_checker.sv
`default_nettype none
module keyframe_track_lerp_sampler_checker (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [6:0]        cfg_data_i,
  input  wire logic              in_valid_i,
  input  wire logic              in_ready_i,
  input  wire ktls_pkg::in_item_t  in_data_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_ready_i,
  input  wire ktls_pkg::out_item_t out_data_i,
  output int                     fail_count_o,
  output int                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ktls_pkg::*;

  logic [31:0] key_t_mem [64];
  logic [31:0] key_x_mem [64];
  logic [31:0] key_y_mem [64];
  logic [31:0] key_z_mem [64];
  logic [6:0]  track_len;
  out_item_t   sample_q [$];

  function automatic logic [31:0] lerp_comp(logic [31:0] a, logic [31:0] b,
                                            longint unsigned f);
    longint sa, sb, p, r;
    sa = longint'($signed(a));
    sb = longint'($signed(b));
    p = (sb - sa) * longint'(f);
    r = sa + (p >>> 16);
    return r[31:0];
  endfunction

  function automatic out_item_t sample_track(logic [31:0] q);
    out_item_t res;
    int n, lo, hi, mid;
    longint unsigned num, den, f;
    res = '0;
    n = (track_len > 64) ? 64 : int'(track_len);
    if (n == 0) return res;
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (key_t_mem[mid] <= q) lo = mid + 1;
      else hi = mid;
    end
    res.valid_res = 1'b1;
    res.next_key = lo[6:0];
    if (lo == 0) begin
      res.out_x = key_x_mem[0]; res.out_y = key_y_mem[0]; res.out_z = key_z_mem[0];
    end else if (lo >= n) begin
      res.out_x = key_x_mem[n-1]; res.out_y = key_y_mem[n-1]; res.out_z = key_z_mem[n-1];
    end else begin
      num = longint'(32'(q - key_t_mem[lo-1])) << 16;
      den = longint'(32'(key_t_mem[lo] - key_t_mem[lo-1]));
      f = (den != 0) ? num / den : 0;
      res.out_x = lerp_comp(key_x_mem[lo-1], key_x_mem[lo], f);
      res.out_y = lerp_comp(key_y_mem[lo-1], key_y_mem[lo], f);
      res.out_z = lerp_comp(key_z_mem[lo-1], key_z_mem[lo], f);
    end
    return res;
  endfunction

  initial fail_count_o = 0;
  assign pending_o = sample_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_r;
    if (!rst_ni) begin
      track_len <= '0;
    end else begin
      if (cfg_we_i) track_len <= cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.opcode == OP_LOAD) begin
          key_t_mem[in_data_i.key_slot] = in_data_i.key_time;
          key_x_mem[in_data_i.key_slot] = in_data_i.key_x;
          key_y_mem[in_data_i.key_slot] = in_data_i.key_y;
          key_z_mem[in_data_i.key_slot] = in_data_i.key_z;
        end else begin
          sample_q.push_back(sample_track(in_data_i.query_time));
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (sample_q.size() == 0) begin
          $error("unexpected result transfer");
          fail_count_o++;
        end else begin
          exp_r = sample_q.pop_front();
          if (out_data_i.valid_res !== exp_r.valid_res) begin
            $error("valid_res exp %0d got %0d", exp_r.valid_res, out_data_i.valid_res);
            fail_count_o++;
          end
          if (out_data_i.out_x !== exp_r.out_x) begin
            $error("out_x exp %0d got %0d", exp_r.out_x, out_data_i.out_x);
            fail_count_o++;
          end
          if (out_data_i.out_y !== exp_r.out_y) begin
            $error("out_y exp %0d got %0d", exp_r.out_y, out_data_i.out_y);
            fail_count_o++;
          end
          if (out_data_i.out_z !== exp_r.out_z) begin
            $error("out_z exp %0d got %0d", exp_r.out_z, out_data_i.out_z);
            fail_count_o++;
          end
          if (out_data_i.next_key !== exp_r.next_key) begin
            $error("next_key exp %0d got %0d", exp_r.next_key, out_data_i.next_key);
            fail_count_o++;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: tb/keyframe_track_lerp_sampler_unit_test.sv
`default_nettype none
module keyframe_track_lerp_sampler_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ktls_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [6:0] cfg_data_i = '0;
  int         fail_count;
  int         pending;
  int         idle_cycles = 0;
  bit         hold_off = 1'b0;
  logic [31:0] cur_time;

  ktls_in_if  in_ch ();
  ktls_out_if out_ch ();

  keyframe_track_lerp_sampler_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  keyframe_track_lerp_sampler_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i,
    .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready), .in_data_i(in_ch.data),
    .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready), .out_data_i(out_ch.data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_off) out_ch.ready <= 1'b0;
      else case ($urandom_range(0, 3))
        0: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(in_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic pause_random();
    int gap;
    gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic load_key(int slot, logic [31:0] t);
    in_item_t it;
    it = $bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom});
    it.opcode = OP_LOAD;
    it.key_slot = slot[5:0];
    it.key_time = t;
    if ($urandom_range(0, 5) == 0) begin
      it.key_x = {$urandom_range(0, 1), 31'h0};
      it.key_y = ~it.key_x;
    end
    send_item(it);
    pause_random();
  endtask

  task automatic sample_at(logic [31:0] q);
    in_item_t it;
    it = $bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom});
    it.opcode = OP_SAMPLE;
    it.query_time = q;
    send_item(it);
    pause_random();
  endtask

  task automatic drain_and_config(logic [6:0] cnt);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= cnt;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic fill_track(int n, int step_max);
    cur_time = $urandom_range(0, 1000);
    for (int i = 0; i < n; i++) begin
      load_key(i, cur_time);
      cur_time = cur_time + $urandom_range(0, step_max);
    end
  endtask

  function automatic logic [31:0] rand_query();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 200);
      default: return $urandom_range(0, cur_time + 100);
    endcase
  endfunction

  initial begin
    int n, samples;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sample_at(32'h0);
    sample_at(32'hFFFF_FFFF);
    load_key(0, 32'h0000_0000);
    load_key(1, 32'h0001_0000);
    load_key(2, 32'h0001_0000);
    load_key(3, 32'hFFFF_FFFF);
    load_key(63, 32'hFFFF_FFFF);
    drain_and_config(7'd4);
    sample_at(32'h0);
    sample_at(32'h0000_8000);
    sample_at(32'h0001_0000);
    sample_at(32'hFFFF_FFFE);
    sample_at(32'hFFFF_FFFF);
    drain_and_config(7'd1);
    sample_at(32'h0);
    sample_at(32'hFFFF_FFFF);
    for (int i = 4; i < 64; i++) load_key(i, 32'hFFFF_FFFF);
    drain_and_config(7'd100);
    sample_at(32'h1234_5678);
    sample_at(32'hFFFF_FFFF);
    fill_track(64, 32'h0100_0000 / 64);
    drain_and_config(7'd64);
    fork
      begin
        hold_off <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off <= 1'b0;
      end
      for (int i = 0; i < 12; i++) sample_at(rand_query());
    join
    for (int ph = 0; ph < 12; ph++) begin
      n = (ph == 11) ? 64 : $urandom_range(1, 64);
      fill_track(n, (ph % 3 == 0) ? 8 : 32'h0200_0000 / n);
      if (ph % 4 == 1) load_key($urandom_range(0, n - 1), $urandom);
      drain_and_config(n[6:0]);
      samples = 10;
      for (int i = 0; i < samples; i++) begin
        if ($urandom_range(0, 9) == 0) load_key($urandom_range(n, 63), $urandom);
        sample_at(rand_query());
      end
    end
    drain_and_config(7'd0);
    sample_at($urandom);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire
